[sv/gda_pkg.sv]
`timescale 1ns / 1ps

package gda_pkg;

    localparam int ADD_WIDTH   = 16;
    localparam int DAY_W       = 17;
    localparam int YEAR_W      = 15;
    localparam int MONTHS      = 12;
    localparam int LEAP_CYCLE  = 400;
    localparam int CENTURY     = 100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_DONE
    } gda_state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic walk_step;
        logic result_write;
    } gda_ctrl_t;

    typedef struct packed {
        logic more;
        logic out_busy;
    } gda_stat_t;

    // only the low ADD_WIDTH bits of the day count take part
    function automatic logic [15:0] add_mask();
        logic [15:0] m;
        for (int i = 0; i < 16; i++) begin
            m[i] = (i < ADD_WIDTH);
        end
        return m;
    endfunction

    // leap rule from the year taken modulo 400
    function automatic logic is_leap(input logic [YEAR_W-1:0] ymod);
        logic cent;
        cent = (ymod == YEAR_W'(CENTURY)) || (ymod == YEAR_W'(2 * CENTURY))
            || (ymod == YEAR_W'(3 * CENTURY));
        return (ymod == '0) || (!cent && (ymod[1:0] == 2'b00));
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if ((m <= 4'd7 && m[0]) || (m >= 4'd8 && !m[0])) begin
            len = 5'd31;
        end
        else begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage

[sv/gregorian_date_add_days_core.sv]
`timescale 1ns / 1ps
// a load step, then the year is reduced modulo 400 by repeated subtraction, then one
// month length is subtracted per step, then the result is written to the output
// register once free; only then is the next word taken, as the subtractor is shared
// a finished word waits in the output register while the next word is taken in
// reset: rst_n asynchronous active low, clears sequencer and output valid

module gregorian_date_add_days_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  start_day,
    input  logic [3:0]  start_month,
    input  logic [13:0] start_year,
    input  logic [15:0] days_to_add,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  result_day,
    output logic [3:0]  result_month,
    output logic [13:0] result_year
);
    import gda_pkg::*;

    gda_ctrl_t ctrl;
    gda_stat_t stat;

    gda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    gda_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_day    (start_day),
        .start_month  (start_month),
        .start_year   (start_year),
        .days_to_add  (days_to_add),
        .ctrl         (ctrl),
        .stat         (stat),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .result_day   (result_day),
        .result_month (result_month),
        .result_year  (result_year)
    );

endmodule

[sv/gda_ctrl.sv]
`timescale 1ns / 1ps

module gda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gda_pkg::gda_stat_t  stat,
    output gda_pkg::gda_ctrl_t  ctrl
);
    import gda_pkg::*;

    gda_state_t state_reg;
    gda_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (!stat.more)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!stat.more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready          = 1'b0;
        ctrl              = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            ST_MOD:
            begin
                ctrl.mod_step = stat.more;
            end
            ST_WALK:
            begin
                ctrl.walk_step = stat.more;
            end
            ST_DONE:
            begin
                ctrl.result_write = !stat.out_busy;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

[sv/gda_dp.sv]
`timescale 1ns / 1ps

module gda_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [4:0]          start_day,
    input  logic [3:0]          start_month,
    input  logic [13:0]         start_year,
    input  logic [15:0]         days_to_add,
    input  gda_pkg::gda_ctrl_t  ctrl,
    output gda_pkg::gda_stat_t  stat,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [4:0]          result_day,
    output logic [3:0]          result_month,
    output logic [13:0]         result_year
);
    import gda_pkg::*;

    logic [DAY_W-1:0]  day_reg;
    logic [3:0]        month_reg;
    logic [YEAR_W-1:0] year_reg;
    logic [YEAR_W-1:0] ymod_reg;
    logic              walking_reg;
    logic              out_valid_reg;
    logic [4:0]        res_day_reg;
    logic [3:0]        res_month_reg;
    logic [13:0]       res_year_reg;

    logic [3:0]        m_init;
    logic [YEAR_W-1:0] y_init;
    logic [DAY_W-1:0]  d_init;
    logic [4:0]        mlen;
    logic [DAY_W:0]    op_a;
    logic [DAY_W:0]    op_b;
    logic [DAY_W:0]    diff;
    logic              borrow;

    always_comb
    begin
        m_init = start_month;
        y_init = YEAR_W'(start_year);
        if (start_month == 4'd0)
        begin
            m_init = 4'd1;
        end
        else if (start_month > 4'(MONTHS))
        begin
            m_init = start_month - 4'(MONTHS);
            y_init = YEAR_W'(start_year) + YEAR_W'(1);
        end
        d_init = DAY_W'(start_day) + DAY_W'(days_to_add & add_mask());
    end

    assign mlen = month_length(month_reg, is_leap(ymod_reg));

    // shared subtractor: year reduction mod 400, then month-by-month walk
    always_comb
    begin
        if (walking_reg)
        begin
            op_a = (DAY_W+1)'(day_reg);
            op_b = (DAY_W+1)'(mlen);
        end
        else
        begin
            op_a = (DAY_W+1)'(ymod_reg);
            op_b = (DAY_W+1)'(LEAP_CYCLE);
        end
    end

    assign diff   = op_a - op_b;
    assign borrow = diff[DAY_W];

    assign stat.more     = walking_reg ? (!borrow && (diff != '0)) : !borrow;
    assign stat.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            walking_reg <= 1'b0;
        end
        else if (!walking_reg && !stat.more)
        begin
            walking_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            day_reg   <= d_init;
            month_reg <= m_init;
            year_reg  <= y_init;
            ymod_reg  <= y_init;
        end
        else if (ctrl.mod_step)
        begin
            ymod_reg <= diff[YEAR_W-1:0];
        end
        else if (ctrl.walk_step)
        begin
            day_reg <= diff[DAY_W-1:0];
            if (month_reg >= 4'(MONTHS))
            begin
                month_reg <= 4'd1;
                year_reg  <= year_reg + YEAR_W'(1);
                ymod_reg  <= (ymod_reg == YEAR_W'(LEAP_CYCLE - 1)) ? '0
                             : ymod_reg + YEAR_W'(1);
            end
            else
            begin
                month_reg <= month_reg + 4'd1;
            end
        end
    end

    // output word register, lets the next item start while a result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.result_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.result_write)
        begin
            res_day_reg   <= day_reg[4:0];
            res_month_reg <= month_reg;
            res_year_reg  <= year_reg[13:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_day   = res_day_reg;
    assign result_month = res_month_reg;
    assign result_year  = res_year_reg;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int          MONTHS_PER_YEAR = 12;
    localparam int unsigned DAYS_MASK       = (32'd1 << gda_pkg::ADD_WIDTH) - 32'd1;
    localparam int          HOLD_CYCLES     = 2000;
    localparam int          DRAIN_CYCLES    = 2300;
    localparam int          NUM_ROWS        = 24;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [15:0] days;
    } date_word_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } date_result_t;

    typedef struct packed {
        int day;
        int month;
        int year;
        int days;
        int typed;
        int e_day;
        int e_month;
        int e_year;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [4:0]  start_day = '0;
    logic [3:0]  start_month = '0;
    logic [13:0] start_year = '0;
    logic [15:0] days_to_add = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;

    date_result_t offer_date = '0;
    date_result_t due_date;
    date_result_t due_dates [$];
    int           errors = 0;
    int           stall_pct = 0;
    int           hold_asks = 0;

    // day, month, year, days, typed, expected day, month, year
    stim_row_t dir_rows [NUM_ROWS] = '{
        '{1, 1, 2000, 0, 1, 1, 1, 2000},
        '{31, 12, 1999, 1, 1, 1, 1, 2000},
        '{28, 2, 2000, 1, 1, 29, 2, 2000},
        '{28, 2, 1900, 1, 1, 1, 3, 1900},
        '{28, 2, 2004, 1, 1, 29, 2, 2004},
        '{28, 2, 2003, 1, 1, 1, 3, 2003},
        '{31, 1, 2001, 0, 1, 31, 1, 2001},
        '{0, 5, 2010, 0, 1, 0, 5, 2010},
        '{0, 5, 2010, 1, 1, 1, 5, 2010},
        '{15, 0, 2010, 0, 1, 15, 1, 2010},
        '{10, 13, 2010, 0, 1, 10, 1, 2011},
        '{10, 15, 2010, 0, 1, 10, 3, 2011},
        '{31, 2, 2001, 0, 1, 3, 3, 2001},
        '{31, 4, 2001, 0, 1, 1, 5, 2001},
        '{1, 1, 0, 0, 1, 1, 1, 0},
        '{29, 2, 0, 0, 1, 29, 2, 0},
        '{31, 12, 16383, 1, 1, 1, 1, 0},
        '{0, 0, 0, 0, 1, 0, 1, 0},
        '{31, 15, 16383, 0, 1, 31, 3, 0},
        '{1, 1, 9999, 65535, 0, 0, 0, 0},
        '{31, 15, 16383, 65535, 0, 0, 0, 0},
        '{0, 0, 0, 65535, 0, 0, 0, 0},
        '{31, 12, 16383, 65535, 0, 0, 0, 0},
        '{1, 3, 1600, 366, 0, 0, 0, 0}
    };

    gregorian_date_add_days_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_day    (start_day),
        .start_month  (start_month),
        .start_year   (start_year),
        .days_to_add  (days_to_add),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_day   (result_day),
        .result_month (result_month),
        .result_year  (result_year)
    );

    always #10 clk = ~clk;

    function automatic bit leap(input int unsigned y);
        if (y % 400 == 0)
        begin
            return 1'b1;
        end
        if (y % 100 == 0)
        begin
            return 1'b0;
        end
        return (y % 4) == 0;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == 2)
        begin
            return leap(y) ? 29 : 28;
        end
        if ((m <= 7 && m[0]) || (m >= 8 && !m[0]))
        begin
            return 31;
        end
        return 30;
    endfunction

    function automatic date_result_t predict_date(input date_word_t w);
        int unsigned  d;
        int unsigned  m;
        int unsigned  y;
        date_result_t r;
        d = w.day;
        m = w.month;
        y = w.year;
        if (m == 0)
        begin
            m = 1;
        end
        if (m > MONTHS_PER_YEAR)
        begin
            m = m - MONTHS_PER_YEAR;
            y = y + 1;
        end
        d = d + (w.days & DAYS_MASK);
        // year runs wide here, the leap rule sees the full value
        while (d > days_in_month(m, y))
        begin
            d = d - days_in_month(m, y);
            m = m + 1;
            if (m > MONTHS_PER_YEAR)
            begin
                m = 1;
                y = y + 1;
            end
        end
        r.day   = 5'(d);
        r.month = 4'(m);
        r.year  = 14'(y);
        return r;
    endfunction

    function automatic date_word_t make_word();
        date_word_t w;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            w.month = 4'($urandom_range(1, 12));
            if ($urandom_range(0, 19) == 0)
            begin
                w.year = 14'(16383 - $urandom_range(0, 200));
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                w.year = 14'($urandom_range(0, 16383));
            end
            else
            begin
                w.year = 14'($urandom_range(0, 9999));
            end
            w.day = 5'($urandom_range(1, days_in_month(w.month, w.year)));
        end
        else
        begin
            w.day   = 5'($urandom_range(0, 31));
            w.month = 4'($urandom_range(0, 15));
            w.year  = 14'($urandom_range(0, 16383));
        end
        // mostly short spans, a few long walks across the centuries
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            w.days = 16'($urandom_range(0, 400));
        end
        else if (r < 80)
        begin
            w.days = 16'($urandom_range(0, 4000));
        end
        else if (r < 93)
        begin
            w.days = 16'($urandom_range(0, 65535));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: w.days = 16'd0;
                1: w.days = 16'd1;
                2: w.days = 16'hffff;
                default: w.days = 16'(65535 - $urandom_range(0, 63));
            endcase
        end
        return w;
    endfunction

    // returns at the edge where the word is taken
    task automatic send_word(input date_word_t w, input date_result_t e);
        in_valid    <= 1'b1;
        start_day   <= w.day;
        start_month <= w.month;
        start_year  <= w.year;
        days_to_add <= w.days;
        offer_date  <= e;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_gap(input int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < pct);
        end
    endtask

    task automatic run_phase(input int n, input int idle_pct, input int stall);
        date_word_t w;
        stall_pct <= stall;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                idle_gap(idle_pct);
            end
            w = make_word();
            send_word(w, predict_date(w));
        end
    endtask

    task automatic wait_drained();
        while (due_dates.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // receiver: random back-pressure, or one long hold when asked
    initial
    begin
        int hold_served;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // scoreboard: results first, then the word taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_dates.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %0d-%0d-%0d",
                             $time, result_year, result_month, result_day);
                    errors++;
                end
                else
                begin
                    due_date = due_dates.pop_front();
                    if (result_day !== due_date.day)
                    begin
                        $display("%0t: result_day expected %0d actual %0d",
                                 $time, due_date.day, result_day);
                        errors++;
                    end
                    if (result_month !== due_date.month)
                    begin
                        $display("%0t: result_month expected %0d actual %0d",
                                 $time, due_date.month, result_month);
                        errors++;
                    end
                    if (result_year !== due_date.year)
                    begin
                        $display("%0t: result_year expected %0d actual %0d",
                                 $time, due_date.year, result_year);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                due_dates.push_back(offer_date);
            end
        end
    end

    initial
    begin
        date_word_t   w;
        date_result_t e;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            w.day   = 5'(dir_rows[i].day);
            w.month = 4'(dir_rows[i].month);
            w.year  = 14'(dir_rows[i].year);
            w.days  = 16'(dir_rows[i].days);
            if (dir_rows[i].typed != 0)
            begin
                e.day   = 5'(dir_rows[i].e_day);
                e.month = 4'(dir_rows[i].e_month);
                e.year  = 14'(dir_rows[i].e_year);
            end
            else
            begin
                e = predict_date(w);
            end
            send_word(w, e);
        end

        run_phase(62, 0, 0);

        // long receiver hold while words keep coming, so the input backs up
        hold_asks <= hold_asks + 1;
        for (int i = 0; i < 8; i++)
        begin
            w = make_word();
            w.days = 16'($urandom_range(0, 40));
            send_word(w, predict_date(w));
        end
        in_valid <= 1'b0;
        wait_drained();

        run_phase(62, 79, 0);
        run_phase(62, 0, 79);
        run_phase(62, 32, 32);
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && due_dates.size() == 0)
        begin
            $display("gregorian_date_add_days_core regression: pass");
        end
        else
        begin
            $display("gregorian_date_add_days_core regression: fail");
        end
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("gregorian_date_add_days_core regression: fail");
        $finish;
    end

endmodule
